// ----- rtl/video_test_pattern_pixel_assert.svh -----
// Assertion macros for the checker file of the test pattern block.
`ifndef VIDEO_TEST_PATTERN_PIXEL_ASSERT_SVH
`define VIDEO_TEST_PATTERN_PIXEL_ASSERT_SVH

// Clocked assertion, masked while reset is asserted.
`define VTP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds across reset.
`define VTP_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/vtp_pkg.sv -----
// Shared types, constants and helper functions of the test pattern block.
package vtp_pkg;

  localparam int STAGES     = 5;
  localparam int DIM_W      = 13;
  localparam int BUF_W      = 27;
  localparam int CFG_DATA_W = 27;
  localparam int CFG_IDX_W  = 2;
  localparam int COORD_W    = 12;
  localparam int PHASE_W    = 6;
  localparam int PHASE_N    = 1 << PHASE_W;
  localparam int RGB_W      = 24;
  localparam int VPOS_W     = 17;   // scanline position, Q16 of the frame width
  localparam int SCAN_W     = 14;
  localparam int RECIP_K    = 17;   // reciprocal scale for constant division

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_BYTES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT_RGB32 = 2'd3;

  localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 13'd480;
  localparam logic [BUF_W-1:0] RST_BUFFER_BYTES = 27'd1228800;

  localparam logic [DIM_W-1:0] BORDER_PX = 13'd12;
  localparam logic [SCAN_W:0]  SCAN_HALF = 15'd3;

  localparam logic [RGB_W-1:0] RGB_CYAN   = 24'h22D3EE;
  localparam logic [RGB_W-1:0] RGB_CHECK  = 24'h1E293B;
  localparam logic [RGB_W-1:0] RGB_DARK   = 24'h0F172A;
  localparam logic [RGB_W-1:0] RGB_RED    = 24'hEF4444;
  localparam logic [RGB_W-1:0] RGB_SLATE  = 24'h334155;
  localparam logic [RGB_W-1:0] RGB_BLACK  = 24'h000000;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [PHASE_W-1:0] frame_phase;
    logic               camera_on;
  } pixel_req_t;

  typedef struct packed {
    logic [RGB_W-1:0] pixel_rgb;
    logic             status;
  } pixel_rsp_t;

  typedef struct packed {
    logic [STAGES-1:0] en;
    logic [STAGES-1:0] vld;
  } pipe_ctrl_t;

  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic             format;
    logic [DIM_W-1:0] bar_h;
    logic [DIM_W-1:0] h_third;
    logic [DIM_W-1:0] h_two_third;
    logic             too_small;
  } cfg_derived_t;

  // Scanline position for a Q16 angle: polynomial sine, offset to 0..65536.
  // Evaluated at elaboration only.
  function automatic logic [VPOS_W-1:0] sine_v(input logic [31:0] a);
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    q = (64'(a) >> 14) & 64'd3;
    r = 64'(a) & 64'h3FFF;
    if (q[0]) r = 64'd16384 - r;
    u  = r << 1;
    u2 = (u * u) >> 15;
    t  = 64'd21167 - ((u2 * 64'd2611) >> 15);
    t  = 64'd51472 - ((u2 * t) >> 15);
    s  = (u * t) >> 15;
    if (s > 64'd32768) s = 64'd32768;
    v  = (q >= 64'd2) ? (64'd32768 - s) : (64'd32768 + s);
    return v[VPOS_W-1:0];
  endfunction

  // One correction step after a reciprocal estimate that may be one low.
  function automatic logic [15:0] fix_quot(input logic [15:0] n, input logic [15:0] q0,
                                           input logic [4:0] d);
    logic [20:0] prod;
    logic [20:0] rem;
    prod = 21'(q0) * 21'(d);
    rem  = 21'(n) - prod;
    return (rem >= 21'(d)) ? 16'(q0 + 16'd1) : q0;
  endfunction

  // 75% bar colors, repeating every seven bars.
  function automatic logic [RGB_W-1:0] bar_color(input logic [3:0] idx);
    logic [RGB_W-1:0] c;
    unique case (idx)
      4'd0, 4'd7, 4'd14: c = 24'hC0C0C0;
      4'd1, 4'd8, 4'd15: c = 24'hC0C000;
      4'd2, 4'd9:        c = 24'h00C0C0;
      4'd3, 4'd10:       c = 24'h00C000;
      4'd4, 4'd11:       c = 24'hC000C0;
      4'd5, 4'd12:       c = 24'hC00000;
      4'd6, 4'd13:       c = 24'h0000C0;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/video_test_pattern_pixel.sv -----
// Top level of the test pattern pixel source: color bars and standby card.
//
// One request carries a pixel position, a frame phase and a camera-on flag;
// one response carries the 0xRRGGBB color and a status bit. The block takes
// one request per clock as long as out_ready stays high; under output
// stalls the request rate follows the response rate. A request passes
// through the five register stages of the datapath: scanline position
// lookup (loaded at the accepting edge), scanline multiply with frame,
// border and horizontal banner tests, scanline distance, vertical tests,
// bar select and output register, whose valid bit is out_valid. Each
// stage holds its item while the stage after it is full and cannot move
// on, so a stall on the output side fills bubbles before in_ready drops.
// Configuration writes take effect on the next request; the derived
// geometry (clamped size, bar height, bar width and edges, banner box,
// buffer size check) is recomputed from the registers in a four-level
// chain whose levels line up with the datapath stages that use them. Bar
// width and the 7/10, 1/3 and 2/3 height fractions use reciprocal multiply
// with one correction step, so no divider sits in the design. Writes are
// expected only while no request is in flight. The block holds no memory
// and needs no clearing pass after reset.
module video_test_pattern_pixel #(
  parameter int MAX_DIM     = 4096,
  parameter int BAR_COUNT   = 7,
  parameter int PHASE_STEPS = 60
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // pixel requests
  input  logic                            in_valid,
  output logic                            in_ready,
  input  vtp_pkg::pixel_req_t             in_data,
  // pixel responses
  output logic                            out_valid,
  input  logic                            out_ready,
  output vtp_pkg::pixel_rsp_t             out_data,
  // register writes
  input  logic                            cfg_we,
  input  logic [vtp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vtp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // bar edges: one threshold per boundary between bars
  localparam int THR_N = (BAR_COUNT > 1) ? BAR_COUNT - 1 : 1;
  localparam int THR_W = vtp_pkg::DIM_W + ((BAR_COUNT > 1) ? $clog2(BAR_COUNT) : 1);

  vtp_pkg::pipe_ctrl_t   ctl;
  vtp_pkg::cfg_derived_t dcfg;
  logic [THR_W-1:0]      thr [THR_N];

  // registers and derived geometry
  vtp_cfg #(
    .MAX_DIM   (MAX_DIM),
    .BAR_COUNT (BAR_COUNT),
    .THR_N     (THR_N),
    .THR_W     (THR_W)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .dcfg      (dcfg),
    .thr       (thr)
  );

  // valid bits and stage enables
  vtp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .ctl       (ctl)
  );

  // pixel datapath
  vtp_datapath #(
    .PHASE_STEPS (PHASE_STEPS),
    .BAR_COUNT   (BAR_COUNT),
    .THR_N       (THR_N),
    .THR_W       (THR_W)
  ) u_dp (
    .clk      (clk),
    .ctl      (ctl),
    .in_data  (in_data),
    .dcfg     (dcfg),
    .thr      (thr),
    .out_data (out_data)
  );

  assign out_valid = ctl.vld[vtp_pkg::STAGES-1];

endmodule

// ----- rtl/vtp_cfg.sv -----
// Configuration registers and the derived frame geometry chain.
module vtp_cfg #(
  parameter int MAX_DIM   = 4096,
  parameter int BAR_COUNT = 7,
  parameter int THR_N     = 6,
  parameter int THR_W     = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [vtp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [vtp_pkg::CFG_DATA_W-1:0]      cfg_data,
  output vtp_pkg::cfg_derived_t               dcfg,
  output logic [THR_W-1:0]                    thr [THR_N]
);

  localparam int DW = vtp_pkg::DIM_W;
  localparam int K  = vtp_pkg::RECIP_K;
  localparam logic [17:0] R_BAR = 18'((2 ** K) / BAR_COUNT);
  localparam logic [17:0] R_10  = 18'((2 ** K) / 10);
  localparam logic [17:0] R_3   = 18'((2 ** K) / 3);

  // registers
  logic [DW-1:0]               width_r, width_nxt;
  logic [DW-1:0]               height_r, height_nxt;
  logic [vtp_pkg::BUF_W-1:0]   buffer_r, buffer_nxt;
  logic                        format_r, format_nxt;

  // level 1: clamped dimensions
  logic [DW-1:0] w1_r, w1_nxt, h1_r, h1_nxt;
  // level 2: area and quotient estimates
  logic [2*DW-1:0] area2_r, area2_nxt;
  logic [15:0]     bh_q0_r, bh_q0_nxt, bw_q0_r, bw_q0_nxt;
  logic [15:0]     h3_q0_r, h3_q0_nxt, h23_q0_r, h23_q0_nxt;
  // level 3: exact quotients and size check
  logic [DW-1:0]   bar_h3_r, bar_h3_nxt, bw3_r, bw3_nxt;
  logic [DW-1:0]   h3_3_r, h3_3_nxt, h23_3_r, h23_3_nxt;
  logic            small3_r, small3_nxt;
  // level 4: bar edges
  logic [THR_W-1:0] thr_r [THR_N];
  logic [THR_W-1:0] thr_nxt [THR_N];

  logic [15:0] n_bh, n_bw, n_h3, n_h23;
  logic [33:0] p_bh, p_bw, p_h3, p_h23;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    buffer_nxt = buffer_r;
    format_nxt = format_r;
    if (cfg_we) begin
      unique case (cfg_index)
        vtp_pkg::CFG_FRAME_WIDTH:  width_nxt  = cfg_data[DW-1:0];
        vtp_pkg::CFG_FRAME_HEIGHT: height_nxt = cfg_data[DW-1:0];
        vtp_pkg::CFG_BUFFER_BYTES: buffer_nxt = cfg_data[vtp_pkg::BUF_W-1:0];
        vtp_pkg::CFG_FORMAT_RGB32: format_nxt = cfg_data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= vtp_pkg::RST_FRAME_WIDTH;
      height_r <= vtp_pkg::RST_FRAME_HEIGHT;
      buffer_r <= vtp_pkg::RST_BUFFER_BYTES;
      format_r <= 1'b1;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      buffer_r <= buffer_nxt;
      format_r <= format_nxt;
    end
  end

  always_comb begin
    w1_nxt = (17'(width_r) > 17'(MAX_DIM)) ? DW'(MAX_DIM) : width_r;
    h1_nxt = (17'(height_r) > 17'(MAX_DIM)) ? DW'(MAX_DIM) : height_r;

    n_bh  = 16'(h1_r) * 16'd7;
    n_bw  = 16'(w1_r);
    n_h3  = 16'(h1_r);
    n_h23 = 16'(h1_r) << 1;
    p_bh  = 34'(n_bh) * 34'(R_10);
    p_bw  = 34'(n_bw) * 34'(R_BAR);
    p_h3  = 34'(n_h3) * 34'(R_3);
    p_h23 = 34'(n_h23) * 34'(R_3);
    area2_nxt  = (2*DW)'(w1_r) * (2*DW)'(h1_r);
    bh_q0_nxt  = p_bh[K+15:K];
    bw_q0_nxt  = p_bw[K+15:K];
    h3_q0_nxt  = p_h3[K+15:K];
    h23_q0_nxt = p_h23[K+15:K];

    bar_h3_nxt = DW'(vtp_pkg::fix_quot(n_bh, bh_q0_r, 5'd10));
    bw3_nxt    = DW'(vtp_pkg::fix_quot(n_bw, bw_q0_r, 5'(BAR_COUNT)));
    h3_3_nxt   = DW'(vtp_pkg::fix_quot(n_h3, h3_q0_r, 5'd3));
    h23_3_nxt  = DW'(vtp_pkg::fix_quot(n_h23, h23_q0_r, 5'd3));
    small3_nxt = {1'b0, buffer_r} < {area2_r, 2'b00};

    for (int k = 0; k < THR_N; k++) begin
      thr_nxt[k] = (BAR_COUNT > 1) ? THR_W'(THR_W'(bw3_r) * THR_W'(k + 1)) : '0;
    end
  end

  // derived values recompute every cycle; a write passes through levels 1 to 4 in turn
  always_ff @(posedge clk) begin
    w1_r     <= w1_nxt;
    h1_r     <= h1_nxt;
    area2_r  <= area2_nxt;
    bh_q0_r  <= bh_q0_nxt;
    bw_q0_r  <= bw_q0_nxt;
    h3_q0_r  <= h3_q0_nxt;
    h23_q0_r <= h23_q0_nxt;
    bar_h3_r <= bar_h3_nxt;
    bw3_r    <= bw3_nxt;
    h3_3_r   <= h3_3_nxt;
    h23_3_r  <= h23_3_nxt;
    small3_r <= small3_nxt;
    thr_r    <= thr_nxt;
  end

  assign dcfg.w           = w1_r;
  assign dcfg.h           = h1_r;
  assign dcfg.format      = format_r;
  assign dcfg.bar_h       = bar_h3_r;
  assign dcfg.h_third     = h3_3_r;
  assign dcfg.h_two_third = h23_3_r;
  assign dcfg.too_small   = small3_r;
  assign thr              = thr_r;

endmodule

// ----- rtl/vtp_ctrl.sv -----
// Valid tracking and per-stage advance enables for the pixel pipeline.
module vtp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                out_ready,
  output logic                in_ready,
  output vtp_pkg::pipe_ctrl_t ctl
);

  localparam int S = vtp_pkg::STAGES;

  logic [S-1:0] vld_r, vld_nxt;
  logic [S-1:0] en;

  // a stage may load when it is empty or its content moves on
  always_comb begin
    en[S-1] = !vld_r[S-1] || out_ready;
    for (int i = S - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  assign in_ready = en[0] && rst_n;

  always_comb begin
    vld_nxt[0] = en[0] ? (in_valid && in_ready) : vld_r[0];
    for (int i = 1; i < S; i++) begin
      vld_nxt[i] = en[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign ctl.en  = en;
  assign ctl.vld = vld_r;

endmodule

// ----- rtl/vtp_datapath.sv -----
// Five-stage pixel datapath: scanline position, region tests, color select.
module vtp_datapath #(
  parameter int PHASE_STEPS = 60,
  parameter int BAR_COUNT   = 7,
  parameter int THR_N       = 6,
  parameter int THR_W       = 16
) (
  input  logic                  clk,
  input  vtp_pkg::pipe_ctrl_t   ctl,
  input  vtp_pkg::pixel_req_t   in_data,
  input  vtp_pkg::cfg_derived_t dcfg,
  input  logic [THR_W-1:0]      thr [THR_N],
  output vtp_pkg::pixel_rsp_t   out_data
);

  localparam int DW   = vtp_pkg::DIM_W;
  localparam int CW   = vtp_pkg::COORD_W;
  localparam int VW   = vtp_pkg::VPOS_W;
  localparam int SW   = vtp_pkg::SCAN_W;
  localparam int IDXW = (BAR_COUNT > 1) ? $clog2(BAR_COUNT) : 1;

  // scanline position per phase code, phase reduced at elaboration
  logic [VW-1:0] vpos [vtp_pkg::PHASE_N];
  for (genvar gi = 0; gi < vtp_pkg::PHASE_N; gi++) begin : g_vpos
    localparam int unsigned PIDX = gi % PHASE_STEPS;
    localparam int unsigned ANG  = (PIDX * 65536) / PHASE_STEPS;
    assign vpos[gi] = vtp_pkg::sine_v(32'(ANG));
  end

  // stage 1
  logic [CW-1:0] s1_x_r, s1_y_r;
  logic          s1_cam_r;
  logic [VW-1:0] s1_v_r;
  // stage 2
  logic [CW-1:0] s2_x_r, s2_y_r;
  logic          s2_cam_r, s2_inside_r, s2_border_r, s2_bnx_r, s2_chk_r;
  logic [SW-1:0] s2_scan_r;
  logic [SW-1:0] s2_scan_nxt;
  logic          s2_inside_nxt, s2_border_nxt, s2_bnx_nxt;
  logic [2*SW+1:0] scan_prod;
  logic [DW-1:0]   x13, y13;
  // stage 3
  logic [CW-1:0] s3_x_r, s3_y_r;
  logic          s3_cam_r, s3_on_r, s3_inside_r, s3_border_r, s3_bnx_r, s3_chk_r;
  logic          s3_on_nxt;
  logic [SW:0]   xa, sa;
  // stage 4
  logic [CW-1:0] s4_x_r;
  logic          s4_cam_r, s4_on_r, s4_inside_r, s4_border_r, s4_bn_r, s4_chk_r, s4_top_r;
  logic          s4_bn_nxt, s4_top_nxt;
  logic [DW-1:0] y3;
  // stage 5 (output)
  vtp_pkg::pixel_rsp_t out_r, out_nxt;
  logic [THR_N-1:0]          ge;
  logic [IDXW-1:0]           idx;
  logic [vtp_pkg::RGB_W-1:0] bars_rgb, standby_rgb;

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      s1_x_r   <= in_data.pixel_x;
      s1_y_r   <= in_data.pixel_y;
      s1_cam_r <= in_data.camera_on;
      s1_v_r   <= vpos[in_data.frame_phase];
    end
  end

  // scan column, frame, border and banner column tests on the clamped size
  always_comb begin
    x13           = DW'(s1_x_r);
    y13           = DW'(s1_y_r);
    scan_prod     = (2*SW+2)'(s1_v_r) * (2*SW+2)'(dcfg.w);
    s2_scan_nxt   = scan_prod[2*SW+1:16];
    s2_inside_nxt = (x13 < dcfg.w) && (y13 < dcfg.h);
    s2_border_nxt = (x13 < vtp_pkg::BORDER_PX) || (x13 + vtp_pkg::BORDER_PX >= dcfg.w) ||
                    (y13 < vtp_pkg::BORDER_PX) || (y13 + vtp_pkg::BORDER_PX >= dcfg.h);
    s2_bnx_nxt    = (x13 > (dcfg.w >> 2)) &&
                    (x13 < DW'(((DW+2)'(dcfg.w) * (DW+2)'(3)) >> 2));
  end

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      s2_x_r      <= s1_x_r;
      s2_y_r      <= s1_y_r;
      s2_cam_r    <= s1_cam_r;
      s2_scan_r   <= s2_scan_nxt;
      s2_inside_r <= s2_inside_nxt;
      s2_border_r <= s2_border_nxt;
      s2_bnx_r    <= s2_bnx_nxt;
      s2_chk_r    <= s1_x_r[5] ^ s1_y_r[5];
    end
  end

  // on the scanline when the signed distance is within three pixels
  always_comb begin
    xa        = (SW+1)'(s2_x_r) + vtp_pkg::SCAN_HALF;
    sa        = (SW+1)'(s2_scan_r) + vtp_pkg::SCAN_HALF;
    s3_on_nxt = (xa >= (SW+1)'(s2_scan_r)) && ((SW+1)'(s2_x_r) <= sa);
  end

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      s3_x_r      <= s2_x_r;
      s3_y_r      <= s2_y_r;
      s3_cam_r    <= s2_cam_r;
      s3_on_r     <= s3_on_nxt;
      s3_inside_r <= s2_inside_r;
      s3_border_r <= s2_border_r;
      s3_bnx_r    <= s2_bnx_r;
      s3_chk_r    <= s2_chk_r;
    end
  end

  always_comb begin
    y3         = DW'(s3_y_r);
    s4_top_nxt = y3 < dcfg.bar_h;
    s4_bn_nxt  = s3_bnx_r && (y3 > dcfg.h_third) && (y3 < dcfg.h_two_third);
  end

  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      s4_x_r      <= s3_x_r;
      s4_cam_r    <= s3_cam_r;
      s4_on_r     <= s3_on_r;
      s4_inside_r <= s3_inside_r;
      s4_border_r <= s3_border_r;
      s4_bn_r     <= s4_bn_nxt;
      s4_chk_r    <= s3_chk_r;
      s4_top_r    <= s4_top_nxt;
    end
  end

  // bar index = number of bar edges at or left of x; saturates by construction
  always_comb begin
    for (int k = 0; k < THR_N; k++) begin
      ge[k] = (BAR_COUNT > 1) && (THR_W'(s4_x_r) >= thr[k]);
    end
    idx = IDXW'($countones(ge));

    if (s4_top_r)      bars_rgb = vtp_pkg::bar_color(4'(idx));
    else if (s4_on_r)  bars_rgb = vtp_pkg::RGB_CYAN;
    else if (!s4_chk_r) bars_rgb = vtp_pkg::RGB_CHECK;
    else               bars_rgb = vtp_pkg::RGB_DARK;

    if (s4_border_r)   standby_rgb = vtp_pkg::RGB_RED;
    else if (s4_bn_r)  standby_rgb = vtp_pkg::RGB_SLATE;
    else               standby_rgb = vtp_pkg::RGB_DARK;

    out_nxt.status    = dcfg.too_small;
    out_nxt.pixel_rgb = vtp_pkg::RGB_BLACK;
    if (!dcfg.too_small && dcfg.format && s4_inside_r) begin
      out_nxt.pixel_rgb = s4_cam_r ? bars_rgb : standby_rgb;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[4]) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

// ----- rtl/vtp_checker.sv -----
// Port-level checks of the test pattern block and their bind.
`include "video_test_pattern_pixel_assert.svh"

module vtp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input vtp_pkg::pixel_rsp_t out_data
);

  // a stalled response holds
  `VTP_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled response changed")

  // an error status always comes with a black pixel
  `VTP_ASSERT(a_err_black, clk, rst_n, out_valid && out_data.status |-> out_data.pixel_rgb == 24'd0, "error response with nonzero pixel")

  // backpressure only when every stage is full and the output is stalled
  `VTP_ASSERT(a_ready_only_full, clk, rst_n, rst_n && !in_ready |-> out_valid && !out_ready, "request refused with room in the pipeline")

  // reset empties the pipeline
  `VTP_ASSERT_NR(a_reset_empty, clk, !rst_n |=> !out_valid, "response valid right after reset")

endmodule

bind video_test_pattern_pixel vtp_checker u_vtp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- tb/testbench.sv -----
// Self-checking testbench for the test pattern pixel source (bars, scanline, standby card).
module testbench;
  import vtp_pkg::*;

  // Run bounds. The block answers every request after five stages, so
  // the drain allowance only needs to cover one pipeline depth plus margin.
  localparam int LIMIT_CYCLES  = 400000;
  localparam int DRAIN_CYCLES  = 10;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 160;
  localparam int STEADY_PHASE  = 3;    // phase run with neither side idling

  // Geometry of the pattern.
  localparam int DIM_CLAMP   = 4096;
  localparam int BARS        = 7;
  localparam int PHASE_STEPS = 60;
  localparam int BORDER      = 12;
  localparam int SCAN_REACH  = 4;      // |x - scan column| below this is on the line

  localparam logic [BUF_W-1:0] BUF_ALL_ONES = '1;

  // 75% bar colors, element 0 is the leftmost bar.
  localparam logic [6:0][RGB_W-1:0] BAR_RGB = {
    24'h0000C0, 24'hC00000, 24'hC000C0, 24'h00C000,
    24'h00C0C0, 24'hC0C000, 24'hC0C0C0
  };

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  pixel_req_t in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  pixel_rsp_t out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  video_test_pattern_pixel DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Register values as the block holds them; start at the reset values.
  logic [DIM_W-1:0] frame_w_now   = RST_FRAME_WIDTH;
  logic [DIM_W-1:0] frame_h_now   = RST_FRAME_HEIGHT;
  logic [BUF_W-1:0] buf_bytes_now = RST_BUFFER_BYTES;
  logic             rgb32_now     = 1'b1;

  // Responses still owed by the block, oldest first.
  pixel_rsp_t expected_pixels[$];

  int  mismatches    = 0;
  int  results_seen  = 0;
  int  requests_sent = 0;
  int  settings_used = 0;
  int  cycle_count   = 0;
  bit  steady        = 1'b0;

  // Directed rows: register setting, request, and optionally a hand-typed answer.
  typedef struct {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [BUF_W-1:0] bytes;
    logic             fmt;
    pixel_req_t       req;
    bit               typed;
    pixel_rsp_t       want;
  } directed_row_t;

  directed_row_t directed_rows[$];

  // ------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------

  function automatic int clamp_dim(input logic [DIM_W-1:0] d);
    return (int'(d) > DIM_CLAMP) ? DIM_CLAMP : int'(d);
  endfunction

  // Column of the animated scanline: Q16 angle from the phase, polynomial
  // sine in Q15, offset to 0..65536 and scaled by the clamped width.
  function automatic int scanline_col(input logic [PHASE_W-1:0] phase, input int w_eff);
    logic [63:0] ang;
    logic [63:0] quad;
    logic [63:0] frac;
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    ang  = ((64'(phase) % 64'(PHASE_STEPS)) * 64'd65536) / 64'(PHASE_STEPS);
    quad = (ang >> 14) & 64'd3;
    frac = ang & 64'h3FFF;
    if (quad[0]) frac = 64'd16384 - frac;
    u  = frac << 1;
    u2 = (u * u) >> 15;
    t  = 64'd21167 - ((u2 * 64'd2611) >> 15);
    t  = 64'd51472 - ((u2 * t) >> 15);
    s  = (u * t) >> 15;
    if (s > 64'd32768) s = 64'd32768;
    v  = (quad >= 64'd2) ? (64'd32768 - s) : (64'd32768 + s);
    return int'((v * 64'(w_eff)) >> 16);
  endfunction

  function automatic pixel_rsp_t predict_pixel(input pixel_req_t req);
    int          w_eff;
    int          h_eff;
    int          x;
    int          y;
    int          diff;
    int          bar_w;
    int          idx;
    logic [63:0] need;
    pixel_rsp_t  rsp;
    w_eff = clamp_dim(frame_w_now);
    h_eff = clamp_dim(frame_h_now);
    need  = 64'(w_eff) * 64'(h_eff) * 64'd4;
    x     = int'(req.pixel_x);
    y     = int'(req.pixel_y);
    rsp   = '0;
    if (64'(buf_bytes_now) < need) begin
      rsp.status = 1'b1;
    end else if (rgb32_now && x < w_eff && y < h_eff) begin
      if (req.camera_on) begin
        if (y < (h_eff * 7) / 10) begin
          // Bars; a width under seven pixels puts every pixel in the last bar.
          bar_w = w_eff / BARS;
          idx   = (bar_w == 0) ? BARS - 1 : x / bar_w;
          if (idx > BARS - 1) idx = BARS - 1;
          rsp.pixel_rgb = BAR_RGB[idx % 7];
        end else begin
          diff = x - scanline_col(req.frame_phase, w_eff);
          if (diff > -SCAN_REACH && diff < SCAN_REACH) rsp.pixel_rgb = RGB_CYAN;
          else if ((((x >> 5) + (y >> 5)) & 1) == 0)   rsp.pixel_rgb = RGB_CHECK;
          else                                         rsp.pixel_rgb = RGB_DARK;
        end
      end else begin
        // Standby card: border first, no wrap on narrow frames.
        if (x < BORDER || x + BORDER >= w_eff || y < BORDER || y + BORDER >= h_eff)
          rsp.pixel_rgb = RGB_RED;
        else if (x > w_eff / 4 && x < (w_eff * 3) / 4 && y > h_eff / 3 && y < (h_eff * 2) / 3)
          rsp.pixel_rgb = RGB_SLATE;
        else
          rsp.pixel_rgb = RGB_DARK;
      end
    end
    return rsp;
  endfunction

  // ------------------------------------------------------------------
  // Response checking
  // ------------------------------------------------------------------

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h want %h at response %0d", field, got, want, results_seen);
    mismatches++;
  endtask

  // Outputs are sampled right after the edge, so they hold the values the
  // handshake was taken on.
  always @(posedge clk) begin : check_response
    pixel_rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_pixels.size() == 0) begin
        report_mismatch("response with no request pending", 32'(out_data), 32'd0);
      end else begin
        want = expected_pixels.pop_front();
        if (out_data.pixel_rgb !== want.pixel_rgb)
          report_mismatch("pixel_rgb", 32'(out_data.pixel_rgb), 32'(want.pixel_rgb));
        if (out_data.status !== want.status)
          report_mismatch("status", 32'(out_data.status), 32'(want.status));
      end
    end
  end

  // Receiver stalls about a third of the time, except in the steady phase.
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 33);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d responses owed", cycle_count,
               expected_pixels.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Request side
  // ------------------------------------------------------------------

  // Holds off the next request until every owed response is back, then
  // lets the pipeline settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Registers are only written with the pipeline empty.
  task automatic apply_setting(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                               input logic [BUF_W-1:0] bytes, input logic fmt);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_data  <= CFG_DATA_W'(w);
    @(posedge clk);
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_data  <= CFG_DATA_W'(h);
    @(posedge clk);
    cfg_index <= CFG_BUFFER_BYTES;
    cfg_data  <= bytes;
    @(posedge clk);
    cfg_index <= CFG_FORMAT_RGB32;
    cfg_data  <= CFG_DATA_W'(fmt);
    @(posedge clk);
    cfg_we        <= 1'b0;
    frame_w_now   = w;
    frame_h_now   = h;
    buf_bytes_now = bytes;
    rgb32_now     = fmt;
    settings_used++;
  endtask

  // Sends one request; valid is only lowered for an idle gap, so a
  // back-to-back request never sees two assignments in one step.
  task automatic issue_pixel(input pixel_req_t req, input bit typed, input pixel_rsp_t want);
    while (!steady && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_pixels.push_back(typed ? want : predict_pixel(req));
    requests_sent++;
  endtask

  task automatic add_row(input int w, input int h, input int bytes, input bit fmt,
                         input int x, input int y, input int ph, input bit cam,
                         input bit typed, input logic [RGB_W-1:0] rgb, input bit st);
    directed_row_t row;
    row.w                 = DIM_W'(w);
    row.h                 = DIM_W'(h);
    row.bytes             = BUF_W'(bytes);
    row.fmt               = fmt;
    row.req.pixel_x       = COORD_W'(x);
    row.req.pixel_y       = COORD_W'(y);
    row.req.frame_phase   = PHASE_W'(ph);
    row.req.camera_on     = cam;
    row.typed             = typed;
    row.want.pixel_rgb    = rgb;
    row.want.status       = st;
    directed_rows.push_back(row);
  endtask

  initial begin : stimulus
    directed_row_t    row;
    pixel_req_t       req;
    pixel_rsp_t       none;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [BUF_W-1:0] bytes;
    logic             fmt;
    logic [63:0]      need;
    int               w_lim;
    int               h_lim;
    int               sel;
    int               x;
    int               y;

    none = '0;

    // Reset values first (no write), then each special case under its own setting.
    //       w     h     bytes     fmt x     y     ph  cam typed rgb          status
    add_row(640,  480,  1228800,  1,  0,    0,    0,  1,  1,    24'hC0C0C0,  0);
    add_row(640,  480,  1228800,  1,  639,  0,    0,  1,  1,    24'h0000C0,  0);
    add_row(640,  480,  1228800,  1,  640,  0,    0,  1,  1,    RGB_BLACK,   0);
    add_row(640,  480,  1228800,  1,  0,    480,  0,  1,  1,    RGB_BLACK,   0);
    add_row(640,  480,  1228800,  1,  4095, 4095, 63, 1,  1,    RGB_BLACK,   0);
    add_row(640,  480,  1228800,  1,  0,    0,    0,  0,  1,    RGB_RED,     0);
    add_row(640,  480,  1228800,  1,  320,  240,  0,  0,  1,    RGB_SLATE,   0);
    add_row(640,  480,  1228800,  1,  100,  100,  0,  0,  1,    RGB_DARK,    0);
    // phase 0 puts the scanline at mid width
    add_row(640,  480,  1228800,  1,  320,  400,  0,  1,  1,    RGB_CYAN,    0);
    add_row(640,  480,  1228800,  1,  323,  400,  0,  1,  0,    RGB_BLACK,   0);
    add_row(640,  480,  1228800,  1,  324,  400,  0,  1,  0,    RGB_BLACK,   0);
    add_row(640,  480,  1228800,  1,  316,  400,  0,  1,  0,    RGB_BLACK,   0);
    // phase above the period wraps
    add_row(640,  480,  1228800,  1,  100,  400,  63, 1,  0,    RGB_BLACK,   0);
    add_row(640,  480,  1228800,  1,  200,  479,  59, 1,  0,    RGB_BLACK,   0);
    // buffer too small, by a lot and by one byte
    add_row(640,  480,  0,        1,  0,    0,    0,  1,  1,    RGB_BLACK,   1);
    add_row(640,  480,  1228799,  1,  10,   10,   0,  1,  1,    RGB_BLACK,   1);
    // format other than RGB32
    add_row(640,  480,  1228800,  0,  0,    0,    0,  1,  1,    RGB_BLACK,   0);
    add_row(640,  480,  1228800,  0,  20,   20,   0,  0,  1,    RGB_BLACK,   0);
    // oversized dimensions clamp to 4096
    add_row(8191, 8191, 134217727, 1, 4095, 0,    0,  1,  1,    24'h0000C0,  0);
    add_row(8191, 8191, 134217727, 1, 4095, 4095, 30, 1,  0,    RGB_BLACK,   0);
    // zero bar width and narrow border
    add_row(5,    16,   1000,     1,  0,    0,    0,  1,  1,    24'h0000C0,  0);
    add_row(5,    16,   1000,     1,  4,    15,   0,  0,  1,    RGB_RED,     0);
    // empty frame: nothing is inside, size check passes with an empty buffer
    add_row(0,    480,  0,        1,  0,    0,    0,  1,  1,    RGB_BLACK,   0);
    // smallest legal frame with an exact buffer
    add_row(16,   16,   1024,     1,  15,   15,   17, 1,  0,    RGB_BLACK,   0);
    add_row(16,   16,   1024,     1,  15,   15,   17, 0,  1,    RGB_RED,     0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.w != frame_w_now || row.h != frame_h_now ||
          row.bytes != buf_bytes_now || row.fmt != rgb32_now)
        apply_setting(row.w, row.h, row.bytes, row.fmt);
      issue_pixel(row.req, row.typed, row.want);
    end

    // Random phases, each under its own register setting.
    for (int k = 0; k < RANDOM_PHASES; k++) begin
      fmt   = 1'b1;
      bytes = BUF_ALL_ONES;
      case (k)
        0: begin w = RST_FRAME_WIDTH; h = RST_FRAME_HEIGHT; bytes = RST_BUFFER_BYTES; end
        1: begin w = '1; h = '1; end
        2: begin w = 13'd16; h = 13'd16; bytes = 27'd1024; end
        3, 5: begin
          w = DIM_W'($urandom_range(16, 4096));
          h = DIM_W'($urandom_range(16, 4096));
          need  = 64'(w) * 64'(h) * 64'd4;
          bytes = (k == 3) ? BUF_W'(need) : BUF_W'(need - 64'd1);
        end
        4: begin
          w = DIM_W'($urandom_range(16, 800));
          h = DIM_W'($urandom_range(16, 800));
          fmt = 1'b0;
        end
        6: begin w = DIM_W'($urandom_range(0, 20)); h = DIM_W'($urandom_range(0, 40)); end
        7: begin w = 13'd4096; h = 13'd4096; bytes = 27'd67108864; end
        8: begin
          w     = DIM_W'($urandom());
          h     = DIM_W'($urandom());
          bytes = BUF_W'($urandom());
          fmt   = 1'($urandom());
        end
        default: begin w = 13'd1920; h = 13'd1080; bytes = 27'd8294400; end
      endcase
      apply_setting(w, h, bytes, fmt);
      steady = (k == STEADY_PHASE);
      w_lim  = clamp_dim(frame_w_now);
      h_lim  = clamp_dim(frame_h_now);

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        req.frame_phase = PHASE_W'($urandom_range(0, 63));
        req.camera_on   = 1'($urandom_range(0, 1));
        sel = $urandom_range(0, 9);
        // Mostly inside the frame, some aimed at the scanline, some anywhere.
        if (w_lim > 0 && sel < 6) begin
          x = $urandom_range(0, w_lim - 1);
        end else if (w_lim > 0 && sel < 8) begin
          x = scanline_col(req.frame_phase, w_lim) + int'($urandom_range(0, 10)) - 5;
          if (x < 0) x = 0;
          if (x > 4095) x = 4095;
        end else begin
          x = $urandom_range(0, 4095);
        end
        if (h_lim > 0 && sel < 6)      y = $urandom_range(0, h_lim - 1);
        else if (h_lim > 0 && sel < 8) y = $urandom_range((h_lim * 7) / 10, h_lim - 1);
        else                           y = $urandom_range(0, 4095);
        req.pixel_x = COORD_W'(x);
        req.pixel_y = COORD_W'(y);
        issue_pixel(req, 1'b0, none);
        // Hold off once mid-phase until everything owed has come back.
        if (k == 0 && i == PHASE_ITEMS / 2) wait_drained();
      end
    end
    steady = 1'b0;

    wait_drained();

    $display("Sent %0d pixel requests over %0d register settings: bars, scanline, checker,",
             requests_sent, settings_used);
    $display("standby card, clamped and narrow frames, short buffers, black format; %0d checked",
             results_seen);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- video_test_pattern_pixel.f -----
+incdir+rtl
rtl/vtp_pkg.sv
rtl/vtp_cfg.sv
rtl/vtp_ctrl.sv
rtl/vtp_datapath.sv
rtl/video_test_pattern_pixel.sv
rtl/vtp_checker.sv
tb/testbench.sv
